/* rtl/core/bitplane_dma_fetch_sequencer_macros.svh */
// Assertion helpers shared by the bitplane fetch sequencer checkers.
`ifndef BITPLANE_DMA_FETCH_SEQUENCER_MACROS_SVH
`define BITPLANE_DMA_FETCH_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDFS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("bdfs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDFS_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("bdfs: next-cycle check failed");

`endif

/* rtl/core/bdfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdfs_pkg
// Types, codes and sizes shared by the bitplane fetch sequencer modules.
// ----------------------------------------------------------------------------
package bdfs_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int CYCLE_BITS  = 12;

	// planes that can ever be fetched in one unit (lores limit)
	localparam int FETCH_MAX   = (PLANE_COUNT < 6) ? PLANE_COUNT : 6;
	// hires fetches at most planes 1 to 4
	localparam int HIRES_FETCH = (FETCH_MAX < 4) ? FETCH_MAX : 4;
	localparam int CNT_W       = $clog2(FETCH_MAX + 1);
	localparam int FIDX_W      = (FETCH_MAX > 1) ? $clog2(FETCH_MAX) : 1;

	localparam int ADDR_W      = 21;
	localparam int PTR_W       = ADDR_W - 1;
	localparam int PLANE_W     = 3;
	localparam int MOD_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int LORES_OFFSET = 7;
	localparam int HIRES_OFFSET = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input modes
	localparam logic [2:0] MODE_START = 3'd0;
	localparam logic [2:0] MODE_FETCH = 3'd1;
	localparam logic [2:0] MODE_EOF   = 3'd2;
	localparam logic [2:0] MODE_STOP  = 3'd3;
	localparam logic [2:0] MODE_WRPTR = 3'd4;

	// fetch states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LORES = 2'd1;
	localparam logic [1:0] ST_HIRES = 2'd2;

	// result kinds
	localparam logic KIND_FETCH  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DMA_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIRES      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANES     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ODD_MOD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EVEN_MOD   = 3'd4;

	typedef struct packed {
		logic [2:0]         mode;
		logic [11:0]        start_cycle;
		logic               ddf_active;
		logic [2:0]         plane_select;
		logic [ADDR_W-1:0]  pointer_value;
	} in_item_t;

	typedef struct packed {
		logic                  kind;
		logic [PLANE_W-1:0]    plane;
		logic [ADDR_W-1:0]     fetch_address;
		logic [1:0]            dma_state;
		logic [CYCLE_BITS-1:0] next_cycle;
		logic                  last;
	} out_item_t;

	// one classified item waiting for the back end
	typedef struct packed {
		logic [CNT_W-1:0]                 fetch_count;
		logic [FETCH_MAX-1:0][PTR_W-1:0]  ptrs;
		logic [1:0]                       dma_state;
		logic [CYCLE_BITS-1:0]            next_cycle;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/core/bitplane_dma_fetch_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitplane_dma_fetch_sequencer
// Bitplane fetch sequencer: plane pointers, fetch scheduling, word requests.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   (item_valid/item_ready/item): start, fetch, end of frame,
//                  stop and pointer-write events.
//   result channel (result_valid/result_ready/result): for each item, one
//                  word fetch request per fetched plane, then a status item
//                  with last set. All results carry the state after the event.
//   cfg channel    (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//                  write only while no item is in flight.
//   An accepted item is queued first; its results then pass the output register.
//   Throughput: one result per cycle from the output register while the
//   receiver is ready; an item gives 1 to 7 results (planes fetched plus one).
//   A two-entry command queue lets the front take items while results wait.
//   A stalled receiver fills the queue, then item_ready drops.
//   Reset clears pointers, state and config at once; no clearing pass.
// ----------------------------------------------------------------------------
module bitplane_dma_fetch_sequencer import bdfs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output out_item_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t head;

	bdfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	bdfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	bdfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

/* rtl/core/bdfs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdfs_front
// Accepts items and config writes, updates the sequencer state and pointers,
// and pushes one command per item into the queue.
// ----------------------------------------------------------------------------
module bdfs_front import bdfs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  in_item_t               item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   queue_full,
	output logic                   push,
	output cmd_t                   push_cmd
);

	logic                  dma_en_q;
	logic                  hires_q;
	logic [2:0]            planes_q;
	logic [MOD_W-1:0]      odd_mod_q;
	logic [MOD_W-1:0]      even_mod_q;

	logic [PLANE_COUNT-1:0][PTR_W-1:0] ptr_q;
	logic [PLANE_COUNT-1:0][PTR_W-1:0] ptr_d;
	logic [1:0]            state_q, state_d;
	logic [CYCLE_BITS-1:0] sched_q, sched_d;
	logic                  stop_q, stop_d;

	logic [CNT_W-1:0]      en_cnt;
	logic [CNT_W-1:0]      fetch_cnt;
	logic [CYCLE_BITS-1:0] sched_inc;
	logic [1:0]            sched_state;
	logic                  fetch_go;
	logic                  mod_go;
	logic                  wr_go;

	assign item_ready = !queue_full;
	assign push       = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	always_comb begin
		en_cnt = (32'(planes_q) > FETCH_MAX) ? CNT_W'(FETCH_MAX) : CNT_W'(planes_q);
		if (state_q == ST_HIRES && 32'(en_cnt) > HIRES_FETCH) begin
			fetch_cnt = CNT_W'(HIRES_FETCH);
		end else begin
			fetch_cnt = en_cnt;
		end
		sched_inc   = hires_q ? CYCLE_BITS'(HIRES_OFFSET) : CYCLE_BITS'(LORES_OFFSET);
		sched_state = hires_q ? ST_HIRES : ST_LORES;
	end

	// next state of the sequencer for the item on the input
	always_comb begin
		state_d  = state_q;
		sched_d  = sched_q;
		stop_d   = stop_q;
		fetch_go = 1'b0;
		mod_go   = 1'b0;
		wr_go    = 1'b0;
		case (item.mode)
			MODE_START: begin
				if (dma_en_q) begin
					state_d = sched_state;
					sched_d = CYCLE_BITS'(item.start_cycle) + sched_inc;
				end
			end
			MODE_FETCH: begin
				if (!dma_en_q) begin
					state_d = ST_IDLE;
					sched_d = '0;
				end else if (state_q != ST_IDLE) begin
					fetch_go = 1'b1;
					if (item.ddf_active || (stop_q && hires_q)) begin
						stop_d  = 1'b0;
						state_d = sched_state;
						sched_d = sched_q + CYCLE_BITS'(1) + sched_inc;
					end else begin
						state_d = ST_IDLE;
						sched_d = '0;
						mod_go  = 1'b1;
					end
				end
			end
			MODE_EOF: begin
				state_d = ST_IDLE;
				sched_d = '0;
			end
			MODE_STOP: begin
				stop_d = 1'b1;
			end
			MODE_WRPTR: begin
				wr_go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// pointer update: +1 word per fetched plane, then the halved modulo at line end; or a pointer write
	always_comb begin
		logic [MOD_W-1:0] mod_v;
		logic [PTR_W-1:0] step_v;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			mod_v  = (p % 2 == 0) ? odd_mod_q : even_mod_q;
			step_v = '0;
			if (fetch_go && p < 32'(fetch_cnt)) begin
				step_v = step_v + PTR_W'(1);
			end
			if (mod_go && p < 32'(en_cnt)) begin
				step_v = step_v + {{(PTR_W-MOD_W+1){mod_v[MOD_W-1]}}, mod_v[MOD_W-1:1]};
			end
			if (wr_go && 32'(item.plane_select) == p + 1) begin
				ptr_d[p] = item.pointer_value[ADDR_W-1:1];
			end else begin
				ptr_d[p] = ptr_q[p] + step_v;
			end
		end
	end

	always_comb begin
		push_cmd.fetch_count = fetch_go ? fetch_cnt : '0;
		for (int f = 0; f < FETCH_MAX; f++) begin
			push_cmd.ptrs[f] = ptr_q[f];
		end
		push_cmd.dma_state  = state_d;
		push_cmd.next_cycle = sched_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			state_q <= ST_IDLE;
			sched_q <= '0;
			stop_q  <= 1'b0;
		end else if (push) begin
			ptr_q   <= ptr_d;
			state_q <= state_d;
			sched_q <= sched_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_en_q   <= 1'b0;
			hires_q    <= 1'b0;
			planes_q   <= '0;
			odd_mod_q  <= '0;
			even_mod_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DMA_ENABLE: dma_en_q   <= cfg_data[0];
				CFG_HIRES:      hires_q    <= cfg_data[0];
				CFG_PLANES:     planes_q   <= cfg_data[2:0];
				CFG_ODD_MOD:    odd_mod_q  <= cfg_data[MOD_W-1:0];
				CFG_EVEN_MOD:   even_mod_q <= cfg_data[MOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/bdfs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdfs_queue
// Small FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module bdfs_queue import bdfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/bdfs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdfs_back
// Walks the head command: one fetch request per plane, then the status,
// into a registered output stage.
// ----------------------------------------------------------------------------
module bdfs_back import bdfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic [CNT_W-1:0] idx_q;
	logic             valid_q;
	out_item_t        result_q;
	out_item_t        next_res;
	logic             load;
	logic             is_fetch;

	assign load     = head_valid && (!valid_q || result_ready);
	assign is_fetch = (idx_q < head.fetch_count);
	assign pop      = load && !is_fetch;

	always_comb begin
		next_res.dma_state  = head.dma_state;
		next_res.next_cycle = head.next_cycle;
		if (is_fetch) begin
			next_res.kind          = KIND_FETCH;
			next_res.plane         = PLANE_W'(idx_q) + PLANE_W'(1);
			next_res.fetch_address = {head.ptrs[idx_q[FIDX_W-1:0]], 1'b0};
			next_res.last          = 1'b0;
		end else begin
			next_res.kind          = KIND_STATUS;
			next_res.plane         = '0;
			next_res.fetch_address = '0;
			next_res.last          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= is_fetch ? idx_q + CNT_W'(1) : '0;
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= next_res;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

/* rtl/core/bdfs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdfs_checker
// Port-level checks on the result stream of the fetch sequencer.
// ----------------------------------------------------------------------------
`include "bitplane_dma_fetch_sequencer_macros.svh"

module bdfs_checker import bdfs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	`BDFS_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	// only the status closes an item
	`BDFS_ASSERT_IMP(a_last_is_status, clk, arst_n, result_valid, result.last == result.kind)
	`BDFS_ASSERT_IMP(a_status_fields, clk, arst_n, result_valid && result.kind == KIND_STATUS, result.plane == '0 && result.fetch_address == '0)
	`BDFS_ASSERT_IMP(a_fetch_fields, clk, arst_n, result_valid && result.kind == KIND_FETCH, result.plane != '0 && !result.fetch_address[0])
	`BDFS_ASSERT_IMP(a_idle_no_sched, clk, arst_n, result_valid && result.dma_state == ST_IDLE, result.next_cycle == '0)

endmodule

bind bitplane_dma_fetch_sequencer bdfs_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bitplane fetch sequencer against a cycle-free predictor kept
// here. Every accepted item updates the predicted pointers, fetch state and
// schedule. The word requests and the status it should produce are queued,
// and each result item off the output channel is compared with them in order.
// ----------------------------------------------------------------------------
module testbench;
	import bdfs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_TAIL     = 8;
	localparam int ITEM_TARGET    = 130;

	// modes with no defined action
	localparam logic [2:0] MODE_SPARE_A = 3'd5;
	localparam logic [2:0] MODE_SPARE_B = 3'd6;
	localparam logic [2:0] MODE_SPARE_C = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predicted block state and registers
	logic [PTR_W-1:0]      ptr_word [PLANE_COUNT];
	logic [1:0]            seq_state;
	logic [CYCLE_BITS-1:0] unit_cycle;
	logic                  stop_armed;
	logic                  cfg_dma;
	logic                  cfg_hires;
	logic [2:0]            cfg_planes;
	logic [MOD_W-1:0]      cfg_odd_mod;
	logic [MOD_W-1:0]      cfg_even_mod;

	out_item_t fetch_results_q[$];
	out_item_t head_result;
	int        mismatches;
	int        items_sent;
	int        quiet_cycles;
	int        rx_hold;
	bit        no_idle;

	bitplane_dma_fetch_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic int planes_on();
		int n;
		n = cfg_planes;
		if (n > FETCH_MAX) n = FETCH_MAX;
		return n;
	endfunction

	function automatic logic [PTR_W-1:0] bump_ptr(input logic [PTR_W-1:0] w,
			input logic [31:0] bytes);
		logic [31:0] a;
		a = 32'({w, 1'b0}) + bytes;
		return a[ADDR_W-1:1];
	endfunction

	function automatic void go_idle();
		seq_state  = ST_IDLE;
		unit_cycle = '0;
	endfunction

	function automatic void arm_unit(input logic [CYCLE_BITS-1:0] c);
		if (cfg_dma) begin
			if (cfg_hires) begin
				seq_state  = ST_HIRES;
				unit_cycle = CYCLE_BITS'(c + HIRES_OFFSET);
			end else begin
				seq_state  = ST_LORES;
				unit_cycle = CYCLE_BITS'(c + LORES_OFFSET);
			end
		end
	endfunction

	function automatic void predict_fetch_results(input in_item_t ev);
		out_item_t        burst[$];
		out_item_t        r;
		int               n;
		logic [MOD_W-1:0] md;
		case (ev.mode)
			MODE_START: arm_unit(CYCLE_BITS'(ev.start_cycle));
			MODE_FETCH: begin
				if (!cfg_dma) begin
					go_idle();
				end else if (seq_state != ST_IDLE) begin
					n = planes_on();
					if (seq_state == ST_HIRES && n > HIRES_FETCH) n = HIRES_FETCH;
					for (int p = 0; p < n; p++) begin
						r               = '0;
						r.kind          = KIND_FETCH;
						r.plane         = PLANE_W'(p + 1);
						r.fetch_address = {ptr_word[p], 1'b0};
						burst.push_back(r);
						ptr_word[p] = bump_ptr(ptr_word[p], 32'd2);
					end
					if (ev.ddf_active || (stop_armed && cfg_hires)) begin
						stop_armed = 1'b0;
						arm_unit(CYCLE_BITS'(unit_cycle + 1));
					end else begin
						// line end: modulo goes to every enabled plane, even in hires
						n = planes_on();
						go_idle();
						for (int p = 0; p < n; p++) begin
							md = p[0] ? cfg_even_mod : cfg_odd_mod;
							ptr_word[p] = bump_ptr(ptr_word[p], {{(32 - MOD_W){md[MOD_W-1]}}, md});
						end
					end
				end
			end
			MODE_EOF:  go_idle();
			MODE_STOP: stop_armed = 1'b1;
			MODE_WRPTR: begin
				if (ev.plane_select >= 1 && ev.plane_select <= PLANE_COUNT)
					ptr_word[ev.plane_select - 1] = ev.pointer_value[ADDR_W-1:1];
			end
			default: ;
		endcase
		r      = '0;
		r.kind = KIND_STATUS;
		r.last = 1'b1;
		burst.push_back(r);
		foreach (burst[i]) begin
			burst[i].dma_state  = seq_state;
			burst[i].next_cycle = unit_cycle;
			fetch_results_q.push_back(burst[i]);
		end
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_DMA_ENABLE: cfg_dma      = data[0];
			CFG_HIRES:      cfg_hires    = data[0];
			CFG_PLANES:     cfg_planes   = data[2:0];
			CFG_ODD_MOD:    cfg_odd_mod  = data[MOD_W-1:0];
			CFG_EVEN_MOD:   cfg_even_mod = data[MOD_W-1:0];
			default: ;
		endcase
	endfunction

	// ---------------- result checking ----------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (fetch_results_q.size() == 0) begin
				$error("result item with none expected: %p", result);
				mismatches++;
			end else begin
				head_result = fetch_results_q.pop_front();
				check_field("kind", head_result.kind, result.kind);
				check_field("plane", head_result.plane, result.plane);
				check_field("fetch_address", head_result.fetch_address, result.fetch_address);
				check_field("dma_state", head_result.dma_state, result.dma_state);
				check_field("next_cycle", head_result.next_cycle, result.next_cycle);
				check_field("last", head_result.last, result.last);
			end
		end
	end

	// nothing accepted on any channel for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold when a test asks for one
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				result_ready = 1'b0;
				rx_hold--;
			end else begin
				result_ready = no_idle || ($urandom_range(99) >= 10);
			end
		end
	end

	// ---------------- drivers ----------------

	task automatic send_item(input in_item_t ev);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 10) begin
			gap        = $urandom_range(1, 4);
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       = ev;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		predict_fetch_results(ev);
		items_sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// sender rests until every expected result is back and the pipe is quiet
	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		while (fetch_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic load_config(input logic dma, input logic hires, input logic [2:0] planes,
			input logic [MOD_W-1:0] odd_mod, input logic [MOD_W-1:0] even_mod);
		cfg_write(CFG_DMA_ENABLE, CFG_DATA_W'(dma));
		cfg_write(CFG_HIRES, CFG_DATA_W'(hires));
		cfg_write(CFG_PLANES, CFG_DATA_W'(planes));
		cfg_write(CFG_ODD_MOD, CFG_DATA_W'(odd_mod));
		cfg_write(CFG_EVEN_MOD, CFG_DATA_W'(even_mod));
	endtask

	function automatic logic [MOD_W-1:0] pick_modulo();
		case ($urandom_range(5))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'h0000;
			default: return MOD_W'($urandom);
		endcase
	endfunction

	// random content everywhere, so unused fields toggle too
	function automatic in_item_t rand_item(input logic [2:0] mode);
		in_item_t ev;
		ev.mode          = mode;
		ev.start_cycle   = 12'($urandom);
		ev.ddf_active    = 1'($urandom);
		ev.plane_select  = 3'($urandom);
		ev.pointer_value = ADDR_W'($urandom);
		return ev;
	endfunction

	function automatic in_item_t fetch_item(input logic ddf);
		in_item_t ev;
		ev            = rand_item(MODE_FETCH);
		ev.ddf_active = ddf;
		return ev;
	endfunction

	function automatic in_item_t start_item(input logic [11:0] c);
		in_item_t ev;
		ev             = rand_item(MODE_START);
		ev.start_cycle = c;
		return ev;
	endfunction

	function automatic in_item_t ptr_item(input logic [2:0] sel,
			input logic [ADDR_W-1:0] value);
		in_item_t ev;
		ev               = rand_item(MODE_WRPTR);
		ev.plane_select  = sel;
		ev.pointer_value = value;
		return ev;
	endfunction

	// one display line: start, open units, closing unit, with optional pointer writes, stray item, stop and end of frame
	task automatic run_line(input int opens);
		int loads;
		if ($urandom_range(99) < 30) begin
			loads = $urandom_range(1, 3);
			repeat (loads)
				send_item(ptr_item(($urandom_range(99) < 90) ? 3'($urandom_range(1, 6))
					: 3'($urandom_range(0, 1) * 7), ADDR_W'($urandom)));
		end
		if ($urandom_range(99) < 15)
			send_item(rand_item(3'($urandom_range(0, 7))));
		send_item(start_item(12'($urandom)));
		repeat (opens) send_item(fetch_item(1'b1));
		if ($urandom_range(99) < 25)
			send_item(rand_item(MODE_STOP));
		send_item(fetch_item(1'b0));
		if ($urandom_range(99) < 15)
			send_item(rand_item(MODE_EOF));
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		// registers still at reset: DMA off
		send_item(fetch_item(1'b1));
		send_item(start_item(12'hfff));
		send_item(rand_item(MODE_SPARE_A));
		send_item(rand_item(MODE_SPARE_B));
		send_item(rand_item(MODE_SPARE_C));
		send_item(ptr_item(3'd1, 21'h1fffff));
		send_item(ptr_item(3'd6, 21'h000001));
		send_item(ptr_item(3'd0, 21'h155555));
		send_item(ptr_item(3'd7, 21'h0aaaaa));
		send_item(ptr_item(3'd2, 21'h0aaaaa));
		send_item(ptr_item(3'd3, 21'h155554));
		send_item(ptr_item(3'd4, 21'h1ffffe));
		send_item(ptr_item(3'd5, 21'h000002));
		wait_drained();
		load_config(1'b1, 1'b0, 3'd6, 16'h7fff, 16'h8000);
		send_item(fetch_item(1'b1));           // nothing scheduled yet
		send_item(start_item(12'hfff));        // schedule wraps
		send_item(fetch_item(1'b1));
		send_item(rand_item(MODE_STOP));       // lores ignores the stop
		send_item(fetch_item(1'b0));
		wait_drained();
		load_config(1'b1, 1'b1, 3'd7, 16'h8000, 16'h7fff);
		send_item(start_item(12'hffe));
		send_item(fetch_item(1'b0));           // pending stop gives one more unit
		send_item(fetch_item(1'b0));
		send_item(start_item(12'h000));
		send_item(rand_item(MODE_EOF));
		send_item(start_item(12'h064));
		wait_drained();
		cfg_write(CFG_DMA_ENABLE, CFG_DATA_W'(0));
		send_item(fetch_item(1'b1));           // DMA dropped mid-line
		wait_drained();
		load_config(1'b1, 1'b0, 3'd0, 16'h0000, 16'hffff);
		send_item(start_item(12'h800));
		send_item(fetch_item(1'b0));
	endtask

	task automatic test_output_stall();
		wait_drained();
		load_config(1'b1, 1'b0, 3'd6, pick_modulo(), pick_modulo());
		rx_hold = 120;
		send_item(start_item(12'($urandom)));
		repeat (8) send_item(fetch_item(1'b1));
		send_item(fetch_item(1'b0));
	endtask

	task automatic test_back_to_back();
		wait_drained();
		no_idle = 1'b1;
		load_config(1'b1, 1'b1, 3'd4, pick_modulo(), pick_modulo());
		repeat (4) run_line(2);
		wait_drained();
		no_idle = 1'b0;
	endtask

	task automatic test_random_lines();
		int lines;
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			load_config($urandom_range(99) < 85, 1'($urandom), 3'($urandom_range(0, 7)),
				pick_modulo(), pick_modulo());
			lines = $urandom_range(1, 3);
			repeat (lines) run_line($urandom_range(0, 3));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		mismatches   = 0;
		items_sent   = 0;
		quiet_cycles = 0;
		rx_hold      = 0;
		no_idle      = 1'b0;
		foreach (ptr_word[i]) ptr_word[i] = '0;
		seq_state    = ST_IDLE;
		unit_cycle   = '0;
		stop_armed   = 1'b0;
		cfg_dma      = 1'b0;
		cfg_hires    = 1'b0;
		cfg_planes   = '0;
		cfg_odd_mod  = '0;
		cfg_even_mod = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_output_stall();
		test_back_to_back();
		test_random_lines();

		wait_drained();
		if (mismatches == 0 && fetch_results_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
